[src/heightmap_bilinear_sampler_assert.svh]
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_assert.svh
// Assertion macros shared by the heightmap sampler RTL.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_ASSERT_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_ASSERT_SVH

// same-cycle implication
`define HBS_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HBS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

[src/hbs_pkg.sv]
// ----------------------------------------------------------------------------
// hbs_pkg
// Types and constants for the heightmap bilinear sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

	localparam int H_W     = 16;
	localparam int POS_W   = 24;
	localparam int INV_W   = 24;
	localparam int FC_W    = 6;
	localparam int MUL_W   = 25;
	localparam int PROD_W  = 2 * MUL_W;

	localparam logic [FC_W-1:0]  FC_RESET  = 6'd63;
	localparam logic [INV_W-1:0] INV_RESET = 24'd65536;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic REG_FIELD_COUNT = 1'b0;
	localparam logic REG_INV_WIDTH   = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MULX,
		ST_MULZ,
		ST_CHECK,
		ST_IDX,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_LRP0,
		ST_LRP1,
		ST_LRP2,
		ST_LRP3,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic signed [MUL_W-1:0] a;
		logic signed [MUL_W-1:0] b;
	} mul_req_t;

endpackage

[src/heightmap_bilinear_sampler.sv]
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler
// Bilinear height lookup on a square grid of Q8.8 vertex heights.
// ----------------------------------------------------------------------------
// A write beat (tuser = 0) stores one height and gives no result. A query
// beat (tuser = 1) runs the sequencer from acceptance to a loaded result,
// skipping the reads and interpolations when the cell lies outside the
// grid, and s_tready is low meanwhile; the next beat can be taken in the
// cycle after the load. The sequence is set by one shared 25x25 multiplier,
// used in turn for the two coordinate scalings, the row address and the
// three interpolations, and by the single read port of the height RAM,
// which delivers the four corners one per cycle. The result sits in an
// output register, so the next beat is taken while it waits.
// s_tdata: vertex_index[11:0], height_value[27:12], pos_x[51:28],
// pos_z[75:52], zero pad. m_tdata: height. m_tuser: outside.
// The height RAM has no reset; vertices must be written before they are read.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler
	import hbs_pkg::*;
#(
	parameter int MAX_SIDE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // vertex_index, height_value, pos_x, pos_z, pad
	input  logic [0:0]  s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // height
	output logic [0:0]  m_tuser,   // outside
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
	localparam int AW     = $clog2(DEPTH);
	localparam int SW     = (AW > 13) ? AW : 13;
	localparam int FC_CAP = (MAX_SIDE - 1 > 63) ? 63 : MAX_SIDE - 1;

	state_t state_q, state_d;

	logic [FC_W-1:0]  field_count_q;
	logic [INV_W-1:0] inv_width_q;

	logic signed [POS_W-1:0] px_q, pz_q;
	logic signed [48:0]      gx_q;
	logic [5:0]              cx_q, cz_q;
	logic [15:0]             tx_q, tz_q;
	logic [AW-1:0]           i00_q;
	logic [H_W-1:0]          h00_q, h01_q, h10_q, h11_q, h0_q, h1_q;
	logic [H_W-1:0]          res_h_q;
	logic                    res_o_q;
	logic [H_W-1:0]          out_h_q;
	logic                    out_o_q;
	logic                    m_tvalid_q;

	logic [FC_W-1:0]          fc_eff;
	logic [6:0]               side;
	logic signed [48:0]       gz;
	logic                     outside;
	logic [SW-1:0]            i00_sum;
	logic [SW-1:0]            rd_sum;
	logic [AW-1:0]            rd_addr;
	logic [H_W-1:0]           rdata;
	logic                     wr_en;
	logic [SW-1:0]            wr_idx;
	logic                     out_load;
	logic                     in_beat;
	logic signed [16:0]       diff;
	logic [H_W-1:0]           lerp_base;
	logic [H_W-1:0]           lerp_out;
	mul_req_t                 mul_req;
	logic signed [PROD_W-1:0] prod;

	hbs_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	hbs_ram #(
		.WIDTH (H_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx[AW-1:0]),
		.wdata (s_tdata[27:12]),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	assign fc_eff  = (field_count_q > FC_W'(FC_CAP)) ? FC_W'(FC_CAP) : field_count_q;
	assign side    = 7'(fc_eff) + 7'd1;
	assign gz      = prod[48:0];
	assign outside = gx_q[48] || gz[48] ||
	                 (gx_q[48:24] >= 25'(fc_eff)) || (gz[48:24] >= 25'(fc_eff));
	assign i00_sum = prod[SW-1:0] + SW'(cx_q);

	assign in_beat  = s_tvalid && s_tready;
	assign wr_idx   = SW'(s_tdata[11:0]);
	assign wr_en    = in_beat && (s_tuser[0] == CMD_WRITE) && (32'(s_tdata[11:0]) < DEPTH);
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// floor((b - a) * t / 2^16) + a, only the low 16 bits survive
	assign lerp_out = lerp_base + prod[31:16];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_beat && s_tuser[0] == CMD_QUERY) begin
				state_d = ST_MULX;
			end
			ST_MULX:  state_d = ST_MULZ;
			ST_MULZ:  state_d = ST_CHECK;
			ST_CHECK: state_d = outside ? ST_OUT : ST_IDX;
			ST_IDX:   state_d = ST_RD0;
			ST_RD0:   state_d = ST_RD1;
			ST_RD1:   state_d = ST_RD2;
			ST_RD2:   state_d = ST_RD3;
			ST_RD3:   state_d = ST_LRP0;
			ST_LRP0:  state_d = ST_LRP1;
			ST_LRP1:  state_d = ST_LRP2;
			ST_LRP2:  state_d = ST_LRP3;
			ST_LRP3:  state_d = ST_FIN;
			ST_FIN:   state_d = ST_OUT;
			ST_OUT:   if (out_load) begin
				state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs: handshake, multiplier operands, read address
	always_comb begin
		s_tready  = 1'b0;
		mul_req.a = '0;
		mul_req.b = '0;
		rd_sum    = SW'(i00_q);
		diff      = {h01_q[15], h01_q} - {h00_q[15], h00_q};
		lerp_base = h00_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_MULX: begin
				mul_req.a = {px_q[POS_W-1], px_q};
				mul_req.b = {1'b0, inv_width_q};
			end
			ST_MULZ: begin
				mul_req.a = {pz_q[POS_W-1], pz_q};
				mul_req.b = {1'b0, inv_width_q};
			end
			ST_IDX: begin
				mul_req.a = MUL_W'(cz_q);
				mul_req.b = MUL_W'(side);
			end
			ST_RD0: begin
				rd_sum = i00_sum;
			end
			ST_RD1: begin
				rd_sum = SW'(i00_q) + SW'(1);
			end
			ST_RD2: begin
				rd_sum = SW'(i00_q) + SW'(side);
			end
			ST_RD3: begin
				rd_sum = SW'(i00_q) + SW'(side) + SW'(1);
			end
			ST_LRP0: begin
				mul_req.a = MUL_W'(diff);
				mul_req.b = MUL_W'(tx_q);
			end
			ST_LRP1: begin
				diff      = {h11_q[15], h11_q} - {h10_q[15], h10_q};
				mul_req.a = MUL_W'(diff);
				mul_req.b = MUL_W'(tx_q);
			end
			ST_LRP2: begin
				lerp_base = h10_q;
			end
			ST_LRP3: begin
				diff      = {h1_q[15], h1_q} - {h0_q[15], h0_q};
				mul_req.a = MUL_W'(diff);
				mul_req.b = MUL_W'(tz_q);
			end
			ST_FIN: begin
				lerp_base = h0_q;
			end
			ST_CHECK, ST_OUT: begin
			end
			default: begin
			end
		endcase
		rd_addr = rd_sum[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			field_count_q <= FC_RESET;
			inv_width_q   <= INV_RESET;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index[0])
					REG_FIELD_COUNT: field_count_q <= cfg_data[FC_W-1:0];
					REG_INV_WIDTH:   inv_width_q   <= cfg_data;
					default:         ;
				endcase
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_beat) begin
			px_q <= s_tdata[51:28];
			pz_q <= s_tdata[75:52];
		end
		if (state_q == ST_MULZ) begin
			gx_q <= prod[48:0];
		end
		if (state_q == ST_CHECK) begin
			cx_q    <= gx_q[29:24];
			tx_q    <= gx_q[23:8];
			cz_q    <= gz[29:24];
			tz_q    <= gz[23:8];
			res_h_q <= '0;
			res_o_q <= outside;
		end
		if (state_q == ST_RD0) begin
			i00_q <= rd_addr;
		end
		if (state_q == ST_RD1) begin
			h00_q <= rdata;
		end
		if (state_q == ST_RD2) begin
			h01_q <= rdata;
		end
		if (state_q == ST_RD3) begin
			h10_q <= rdata;
		end
		if (state_q == ST_LRP0) begin
			h11_q <= rdata;
		end
		if (state_q == ST_LRP1) begin
			h0_q <= lerp_out;
		end
		if (state_q == ST_LRP2) begin
			h1_q <= lerp_out;
		end
		if (state_q == ST_FIN) begin
			res_h_q <= lerp_out;
		end
		if (out_load) begin
			out_h_q <= res_h_q;
			out_o_q <= res_o_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = out_h_q;
	assign m_tuser[0] = out_o_q;

`include "heightmap_bilinear_sampler_assert.svh"

	`HBS_ASSERT_NOW(a_outside_zero, clk, arst_n, m_tvalid && m_tuser[0], m_tdata == 16'd0, "outside result with non-zero height")
	`HBS_ASSERT_NEXT(a_query_starts, clk, arst_n, in_beat && s_tuser[0] == CMD_QUERY, state_q == ST_MULX, "query beat did not start the sequencer")
	`HBS_ASSERT_NEXT(a_result_shown, clk, arst_n, out_load, m_tvalid, "finished result not presented")

endmodule

[src/hbs_ram.sv]
// ----------------------------------------------------------------------------
// hbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/hbs_mul.sv]
// ----------------------------------------------------------------------------
// hbs_mul
// Shared signed 25x25 multiplier with a registered product.
// ----------------------------------------------------------------------------
module hbs_mul
	import hbs_pkg::*;
(
	input  logic                     clk,
	input  mul_req_t                 req,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= req.a * req.b;
	end

	assign prod = prod_q;

endmodule

[bench/hbs_checker.sv]
// ----------------------------------------------------------------------------
// hbs_checker
// Watches both streams and the register port of the heightmap sampler, keeps
// its own copy of the vertex heights and registers, predicts the result of
// every accepted query and compares each result beat with the oldest one due.
// ----------------------------------------------------------------------------
module hbs_checker
	import hbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [79:0] s_tdata,   // vertex_index, height_value, pos_x, pos_z, pad
	input  logic [0:0]  s_tuser,   // command
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // height
	input  logic [0:0]  m_tuser,   // outside
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = 4096;

	typedef struct packed {
		logic signed [15:0] height;
		logic               outside;
	} sample_t;

	sample_t            due_samples[$];
	logic signed [15:0] vertex_heights [0:STORE_DEPTH-1];
	logic [5:0]         cells_per_side;
	logic [23:0]        inv_width;
	int                 fails = 0;

	// a + floor((b - a) * t / 2^16)
	function automatic logic signed [15:0] blend(logic signed [15:0] a,
			logic signed [15:0] b, logic [15:0] t);
		longint diff;
		diff = longint'(b) - longint'(a);
		return 16'(longint'(a) + ((diff * longint'(t)) >>> 16));
	endfunction

	function automatic sample_t sample_height(logic [23:0] px, logic [23:0] pz);
		longint             gx;
		longint             gz;
		int                 side;
		int                 base;
		logic signed [15:0] row0;
		logic signed [15:0] row1;
		sample_t            res;
		gx = longint'($signed(px)) * longint'(inv_width);
		gz = longint'($signed(pz)) * longint'(inv_width);
		if (gx < 0 || gz < 0 || (gx >>> 24) >= longint'(cells_per_side) ||
				(gz >>> 24) >= longint'(cells_per_side)) begin
			res.height = '0;
			res.outside = 1'b1;
			return res;
		end
		side = int'(cells_per_side) + 1;
		base = int'(gz >>> 24) * side + int'(gx >>> 24);
		row0 = blend(vertex_heights[base], vertex_heights[base+1], gx[23:8]);
		row1 = blend(vertex_heights[base+side], vertex_heights[base+side+1], gx[23:8]);
		res.height = blend(row0, row1, gz[23:8]);
		res.outside = 1'b0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sample_t want;
		if (!arst_n) begin
			cells_per_side = FC_RESET;
			inv_width = INV_RESET;
			due_samples.delete();
			for (int i = 0; i < STORE_DEPTH; i++)
				vertex_heights[i] = '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FIELD_COUNT: cells_per_side = cfg_data[5:0];
					REG_INV_WIDTH:   inv_width = cfg_data;
					default: ;
				endcase
			end
			// results always trail their queries, so pop before push
			if (m_tvalid && m_tready) begin
				if (due_samples.size() == 0) begin
					$error("result beat with no query outstanding");
					fails++;
				end else begin
					want = due_samples.pop_front();
					if (m_tdata !== want.height) begin
						$error("height: expected %0d, got %0d",
							want.height, $signed(m_tdata));
						fails++;
					end
					if (m_tuser[0] !== want.outside) begin
						$error("outside: expected %0d, got %0d", want.outside, m_tuser[0]);
						fails++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == CMD_WRITE)
					vertex_heights[s_tdata[11:0]] = s_tdata[27:12];
				else
					due_samples.insert(due_samples.size(),
						sample_height(s_tdata[51:28], s_tdata[75:52]));
			end
		end
		fail_count <= fails;
		pending <= due_samples.size();
	end

endmodule

[bench/tb_heightmap_bilinear_sampler.sv]
// ----------------------------------------------------------------------------
// tb_heightmap_bilinear_sampler
// Drives vertex writes and height queries into the sampler through several
// grid and reciprocal settings, with bursty input and a stalling receiver.
// Queries that land inside the grid get their four corners written first.
// ----------------------------------------------------------------------------
module tb_heightmap_bilinear_sampler;
	timeunit 1ns;
	timeprecision 1ps;
	import hbs_pkg::*;

	localparam int STORE_DEPTH = 4096;
	localparam int RUN_LIMIT   = 400000;
	localparam int DRAIN       = 30;
	localparam int POS_MAX     = 8388607;

	localparam int RX_ALWAYS = 0;
	localparam int RX_RANDOM = 1;
	localparam int RX_SPARSE = 2;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic [0:0]  s_tuser = CMD_WRITE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = REG_FIELD_COUNT;
	logic [23:0] cfg_data = '0;

	int          fail_count;
	int          pending;
	int          cycle_count = 0;
	int          burst_left = 0;
	int          rx_mode = RX_ALWAYS;
	int          rx_left = 0;
	bit          written [0:STORE_DEPTH-1];
	logic [5:0]  grid_cells = FC_RESET;
	logic [23:0] grid_inv = INV_RESET;

	heightmap_bilinear_sampler u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	hbs_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("[heightmap_bilinear_sampler] ERROR");
			$finish;
		end
	end

	// receiver: randomly chosen stretches of full rate, coin-flip and long stalls
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(RX_ALWAYS, RX_SPARSE);
			rx_left = $urandom_range(16, 96);
		end
		rx_left--;
		case (rx_mode)
			RX_ALWAYS: m_tready = 1'b1;
			RX_RANDOM: m_tready = 1'($urandom_range(0, 1));
			default:   m_tready = ($urandom_range(0, 5) == 0);
		endcase
	end

	function automatic logic [15:0] any_height();
		case ($urandom_range(0, 7))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			default: return 16'($urandom());
		endcase
	endfunction

	// one beat; valid stays high into the next beat unless a gap is drawn
	task automatic drive_beat(logic [0:0] cmd, logic [11:0] idx, logic [15:0] hv,
			logic [23:0] px, logic [23:0] pz);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 20);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tuser = cmd;
		s_tdata = {4'b0, pz, px, hv, idx};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_vertex(logic [11:0] idx, logic [15:0] hv);
		written[idx] = 1'b1;
		drive_beat(CMD_WRITE, idx, hv, 24'($urandom()), 24'($urandom()));
	endtask

	// corners of an inside cell are written before the query that reads them
	task automatic send_query(logic [23:0] px, logic [23:0] pz);
		longint gx;
		longint gz;
		int     side;
		int     base;
		int     corner [4];
		gx = longint'($signed(px)) * longint'(grid_inv);
		gz = longint'($signed(pz)) * longint'(grid_inv);
		if (gx >= 0 && gz >= 0 && (gx >>> 24) < longint'(grid_cells) &&
				(gz >>> 24) < longint'(grid_cells)) begin
			side = int'(grid_cells) + 1;
			base = int'(gz >>> 24) * side + int'(gx >>> 24);
			corner = '{base, base + 1, base + side, base + side + 1};
			foreach (corner[i])
				if (!written[corner[i]])
					write_vertex(12'(corner[i]), any_height());
		end
		drive_beat(CMD_QUERY, 12'($urandom()), 16'($urandom()), px, pz);
	endtask

	// position mostly inside the grid, now and then right on its far edge
	function automatic logic [23:0] grid_coord();
		longint lim;
		if (grid_cells == 0 || grid_inv == 0)
			return 24'($urandom());
		lim = ((longint'(grid_cells) << 24) + grid_inv - 1) / grid_inv;
		if (lim > POS_MAX)
			lim = POS_MAX;
		if ($urandom_range(0, 9) == 0)
			return 24'(lim - $urandom_range(0, 1));
		return 24'($urandom_range(0, int'(lim)));
	endfunction

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_reg(logic [0:0] idx, logic [23:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		if (idx == REG_FIELD_COUNT)
			grid_cells = val[5:0];
		else
			grid_inv = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic run_phase(logic [5:0] cells, logic [23:0] inv, int n);
		int pick;
		wait_idle();
		set_reg(REG_FIELD_COUNT, {18'b0, cells});
		set_reg(REG_INV_WIDTH, inv);
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				send_query(grid_coord(), grid_coord());
			else if (pick < 70)
				send_query(24'($urandom()), grid_coord());
			else if (pick < 80)
				send_query(24'($urandom()), 24'($urandom()));
			else
				write_vertex(12'($urandom()), any_height());
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset settings: one cell is 256 in position units
		write_vertex(12'd0, 16'h8000);
		write_vertex(12'd1, 16'h7FFF);
		write_vertex(12'd64, 16'h7FFF);
		write_vertex(12'd65, 16'h8000);
		send_query(24'd0, 24'd0);
		send_query(24'd255, 24'd255);
		send_query(24'd128, 24'd0);
		send_query(24'hFFFFFF, 24'd0);
		send_query(24'd0, 24'h800000);
		send_query(24'(62 * 256 + 255), 24'(62 * 256 + 255));
		send_query(24'(63 * 256), 24'd0);
		send_query(24'd0, 24'(63 * 256));
		send_query(24'h7FFFFF, 24'h7FFFFF);
		write_vertex(12'd4095, 16'h7FFF);
		write_vertex(12'd2048, 16'h0000);
		send_query(24'(62 * 256 + 128), 24'(62 * 256 + 128));

		// inside queries also write their fresh corners
		run_phase(FC_RESET, INV_RESET, 30);
		run_phase(6'd1, 24'hFFFFFF, 30);
		run_phase(6'd63, 24'd1, 30);
		run_phase(6'd0, 24'($urandom()), 20);
		run_phase(6'($urandom_range(1, 63)), 24'd0, 20);
		run_phase(6'($urandom_range(1, 63)), 24'($urandom_range(4096, 1 << 20)), 35);
		run_phase(6'd63, 24'd65536, 40);
		wait_idle();

		if (fail_count == 0)
			$display("[heightmap_bilinear_sampler] OK");
		else
			$display("[heightmap_bilinear_sampler] ERROR");
		$finish;
	end

endmodule

[heightmap_bilinear_sampler.f]
+incdir+src
src/hbs_pkg.sv
src/hbs_ram.sv
src/hbs_mul.sv
src/heightmap_bilinear_sampler.sv
bench/hbs_checker.sv
bench/tb_heightmap_bilinear_sampler.sv
